// ----- src/rrsc_pkg.sv -----
// rrsc_pkg: shared types and constants of the radial scan converter.
// Holds the configuration struct, register codes, CORDIC tables and fixed widths.
// No dependencies.
`timescale 1ns / 1ps

package rrsc_pkg;

	// APB register file
	localparam int APB_ADDR_BITS = 4;
	localparam int APB_DATA_BITS = 32;

	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH     = 2'd0,
		REG_IMAGE_HEIGHT    = 2'd1,
		REG_RADIUS_Q4       = 2'd2,
		REG_PIXELS_PER_CELL = 2'd3
	} reg_idx_t;

	localparam logic [12:0] RST_IMAGE_WIDTH     = 13'd1024;
	localparam logic [12:0] RST_IMAGE_HEIGHT    = 13'd1024;
	localparam logic [15:0] RST_RADIUS_Q4       = 16'd7537;
	localparam logic [23:0] RST_PIXELS_PER_CELL = 24'd65536;

	typedef struct packed {
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic [15:0] radius_q4;
		logic [23:0] pixels_per_cell;
	} cfg_t;

	// Kept pixel radius in Q.16; never above radius_q4 << 12
	localparam int RADIUS_BITS = 28;
	localparam int GREEN_BITS  = 8;

	localparam logic [7:0] GREEN_CAP      = 8'd240;
	localparam logic [7:0] GREEN_SAT_AMP  = 8'd60;

	// CORDIC: gain compensation in Q30, arctangents in 2^-32 turn
	localparam int          CORDIC_STEPS    = 24;
	localparam int          GAIN_BITS       = 30;
	localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;

	localparam logic [31:0] ATAN_TURN32 [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

endpackage

// ----- src/rrsc_ifs.sv -----
// rrsc_ifs: valid/ready channel interfaces of the radial scan converter.
// rrsc_in_if carries one range cell, rrsc_out_if one pixel write. No dependencies.
`timescale 1ns / 1ps

interface rrsc_in_if #(
	parameter int ANGLE_BITS = 16
);
	logic                  valid;
	logic                  ready;
	logic [ANGLE_BITS-1:0] start_azimuth;
	logic [ANGLE_BITS-1:0] end_azimuth;
	logic [23:0]           first_range_cell;
	logic [15:0]           cell_index;
	logic [16:0]           cell_count;
	logic [7:0]            amplitude;

	modport source (
		output valid, start_azimuth, end_azimuth, first_range_cell,
		       cell_index, cell_count, amplitude,
		input  ready
	);
	modport sink (
		input  valid, start_azimuth, end_azimuth, first_range_cell,
		       cell_index, cell_count, amplitude,
		output ready
	);
endinterface

interface rrsc_out_if #(
	parameter int COORD_BITS = 12
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] pixel_x;
	logic [COORD_BITS-1:0] pixel_y;
	logic [7:0]            pixel_green;

	modport source (
		output valid, pixel_x, pixel_y, pixel_green,
		input  ready
	);
	modport sink (
		input  valid, pixel_x, pixel_y, pixel_green,
		output ready
	);
endinterface

// ----- src/rrsc_front.sv -----
// rrsc_front: accepts range cells, drops the ones not drawn and computes the radius.
// Stages: input, two-part range multiply, radius check, count/MAX by reciprocal, index modulo.
// Depends on rrsc_pkg and rrsc_in_if.
`timescale 1ns / 1ps

module rrsc_front
	import rrsc_pkg::*;
#(
	parameter int MAX_CELLS_PER_RADIAL = 512,
	parameter int ANGLE_BITS = 16,
	localparam int PAY_BITS = ANGLE_BITS + 1 + RADIUS_BITS + GREEN_BITS
)(
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	rrsc_in_if.sink             cell_in,
	output logic                push_valid,
	input  logic                push_ready,
	output logic [PAY_BITS-1:0] push_data
);

	localparam int SUM_BITS   = ANGLE_BITS + 1;
	localparam int CELL_BITS  = 25;
	localparam int PPC_HALF   = 12;
	localparam int PROD_BITS  = CELL_BITS + PPC_HALF;
	localparam int RFULL_BITS = PROD_BITS + PPC_HALF;
	localparam int CNT_BITS   = 17;
	localparam int IDX_BITS   = 16;
	localparam int REM_BITS   = 17;

	// count / MAX as (count * ceil(2^s / MAX)) >> s, exact for every 17-bit count
	localparam int DIV_SHIFT  = CNT_BITS + $clog2(MAX_CELLS_PER_RADIAL);
	localparam int RECIP_BITS = CNT_BITS + 2;
	localparam int DPROD_BITS = CNT_BITS + RECIP_BITS;
	localparam longint unsigned RECIP_ONE = 64'd1 << DIV_SHIFT;
	localparam logic [RECIP_BITS-1:0] RECIP_M =
		RECIP_BITS'((RECIP_ONE + 64'(MAX_CELLS_PER_RADIAL) - 64'd1) /
		            64'(MAX_CELLS_PER_RADIAL));

	logic en;
	logic bad;

	// stage 1: input register
	logic                  v_s1;
	logic [CELL_BITS-1:0]  cell_s1;
	logic [IDX_BITS-1:0]   idx_s1;
	logic [CNT_BITS-1:0]   cnt_s1;
	logic [SUM_BITS-1:0]   sum_s1;
	logic [7:0]            green_s1;
	// stage 2: partial products
	logic                  v_s2;
	logic [PROD_BITS-1:0]  plo_s2;
	logic [PROD_BITS-1:0]  phi_s2;
	logic [IDX_BITS-1:0]   idx_s2;
	logic [CNT_BITS-1:0]   cnt_s2;
	logic [SUM_BITS-1:0]   sum_s2;
	logic [7:0]            green_s2;
	// stage 3: full radius
	logic                  v_s3;
	logic [RFULL_BITS-1:0] rfull_s3;
	logic [IDX_BITS-1:0]   idx_s3;
	logic [CNT_BITS-1:0]   cnt_s3;
	logic [SUM_BITS-1:0]   sum_s3;
	logic [7:0]            green_s3;
	// stage 4: radius check
	logic                  v_s4;
	logic [IDX_BITS-1:0]   idx_s4;
	logic [CNT_BITS-1:0]   cnt_s4;
	logic [PAY_BITS-1:0]   pay_s4;
	logic                  far;
	// stage 5: quotient count / MAX
	logic                  v_s5;
	logic [IDX_BITS-1:0]   idx_s5;
	logic [CNT_BITS-1:0]   q_s5;
	logic [PAY_BITS-1:0]   pay_s5;
	logic [DPROD_BITS-1:0] dprod;

	// modulo stages (index % step), one index bit each
	logic                  mod_v_s    [IDX_BITS];
	logic [IDX_BITS-1:0]   mod_idx_s  [IDX_BITS];
	logic [CNT_BITS-1:0]   mod_step_s [IDX_BITS];
	logic [REM_BITS-1:0]   mod_rem_s  [IDX_BITS];
	logic [PAY_BITS-1:0]   mod_pay_s  [IDX_BITS];

	// whole front advances unless a kept item waits on a full queue
	assign push_valid    = mod_v_s[IDX_BITS-1] && (mod_rem_s[IDX_BITS-1] == '0);
	assign push_data     = mod_pay_s[IDX_BITS-1];
	assign en            = !(push_valid && !push_ready);
	assign cell_in.ready = en;

	// empty radial or index past the end
	assign bad = (cell_in.cell_count == '0) ||
	             ({1'b0, cell_in.cell_index} >= cell_in.cell_count);

	// radius beyond display radius
	assign far = rfull_s3 > RFULL_BITS'({cfg.radius_q4, 12'b0});

	// reciprocal product for the decimation step
	assign dprod = DPROD_BITS'(cnt_s4) * DPROD_BITS'(RECIP_M);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= cell_in.valid && !bad;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3 && !far;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_s1  <= CELL_BITS'(cell_in.first_range_cell) + CELL_BITS'(cell_in.cell_index);
			idx_s1   <= cell_in.cell_index;
			cnt_s1   <= cell_in.cell_count;
			sum_s1   <= SUM_BITS'(cell_in.start_azimuth) + SUM_BITS'(cell_in.end_azimuth);
			green_s1 <= (cell_in.amplitude > GREEN_SAT_AMP) ? GREEN_CAP
			            : {cell_in.amplitude[5:0], 2'b00};

			plo_s2   <= PROD_BITS'(cell_s1) * PROD_BITS'(cfg.pixels_per_cell[PPC_HALF-1:0]);
			phi_s2   <= PROD_BITS'(cell_s1) * PROD_BITS'(cfg.pixels_per_cell[23:PPC_HALF]);
			idx_s2   <= idx_s1;
			cnt_s2   <= cnt_s1;
			sum_s2   <= sum_s1;
			green_s2 <= green_s1;

			rfull_s3 <= RFULL_BITS'(plo_s2) + {phi_s2, {PPC_HALF{1'b0}}};
			idx_s3   <= idx_s2;
			cnt_s3   <= cnt_s2;
			sum_s3   <= sum_s2;
			green_s3 <= green_s2;

			idx_s4   <= idx_s3;
			cnt_s4   <= cnt_s3;
			pay_s4   <= {sum_s3, rfull_s3[RADIUS_BITS-1:0], green_s3};

			idx_s5   <= idx_s4;
			q_s5     <= CNT_BITS'(dprod >> DIV_SHIFT);
			pay_s5   <= pay_s4;
		end
	end

	// restoring modulo of the index by the step, MSB first
	for (genvar k = 0; k < IDX_BITS; k++) begin : g_mod
		logic                pv;
		logic [IDX_BITS-1:0] pidx;
		logic [CNT_BITS-1:0] pstep;
		logic [REM_BITS-1:0] prem;
		logic [PAY_BITS-1:0] ppay;
		logic [REM_BITS:0]   t;
		logic                ge;
		logic [REM_BITS-1:0] rem_n;

		if (k == 0) begin : g_first
			// step is the quotient, but never below one
			assign pv    = v_s5;
			assign pidx  = idx_s5;
			assign pstep = (q_s5 == '0) ? CNT_BITS'(1) : q_s5;
			assign prem  = '0;
			assign ppay  = pay_s5;
		end else begin : g_next
			assign pv    = mod_v_s[k-1];
			assign pidx  = mod_idx_s[k-1];
			assign pstep = mod_step_s[k-1];
			assign prem  = mod_rem_s[k-1];
			assign ppay  = mod_pay_s[k-1];
		end

		always_comb begin
			t     = {prem, pidx[IDX_BITS-1-k]};
			ge    = (t >= {1'b0, pstep});
			rem_n = ge ? REM_BITS'(t - {1'b0, pstep}) : t[REM_BITS-1:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				mod_v_s[k] <= 1'b0;
			end else if (en) begin
				mod_v_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				mod_idx_s[k]  <= pidx;
				mod_step_s[k] <= pstep;
				mod_rem_s[k]  <= rem_n;
				mod_pay_s[k]  <= ppay;
			end
		end
	end

endmodule

// ----- src/rrsc_fifo.sv -----
// rrsc_fifo: short register queue between the front and the back.
// Full and empty come from a registered fill count. No dependencies.
`timescale 1ns / 1ps

module rrsc_fifo #(
	parameter int WIDTH = 45,
	parameter int DEPTH = 4,
	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_BITS = $clog2(DEPTH + 1)
)(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	localparam logic [PTR_BITS-1:0] LAST = PTR_BITS'(DEPTH - 1);
	localparam logic [CNT_BITS-1:0] FULL = CNT_BITS'(DEPTH);

	logic [WIDTH-1:0]    entry_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                wr;
	logic                rd;

	assign in_ready  = (count_q != FULL);
	assign out_valid = (count_q != '0);
	assign wr        = in_valid && in_ready;
	assign rd        = out_valid && out_ready;
	assign out_data  = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (wr) begin
			entry_q[wr_ptr_q] <= in_data;
		end
	end

endmodule

// ----- src/rrsc_back.sv -----
// rrsc_back: turns a kept cell into a pixel write: gain multiply, 24-stage CORDIC,
// centre offset and rounding, image bounds check, output register.
// Depends on rrsc_pkg and rrsc_out_if.
`timescale 1ns / 1ps

module rrsc_back
	import rrsc_pkg::*;
#(
	parameter int ANGLE_BITS = 16,
	parameter int COORD_BITS = 12,
	localparam int PAY_BITS = ANGLE_BITS + 1 + RADIUS_BITS + GREEN_BITS
)(
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  logic [PAY_BITS-1:0] pop_data,
	rrsc_out_if.source          pixel_out
);

	localparam int SUM_BITS  = ANGLE_BITS + 1;
	localparam int PROD_BITS = RADIUS_BITS + GAIN_BITS;
	localparam int XY_BITS   = 31;
	localparam int Z_BITS    = 32;
	localparam int LIM_BITS  = 15;
	localparam logic [LIM_BITS-1:0] CMAX = LIM_BITS'(1 << COORD_BITS);
	localparam logic [Z_BITS-1:0]   HALF = Z_BITS'(32768);

	logic en;

	// unpacked queue entry and angle fold
	logic [SUM_BITS-1:0]    pop_sum;
	logic [RADIUS_BITS-1:0] pop_r;
	logic [GREEN_BITS-1:0]  pop_green;
	logic [Z_BITS-1:0]      ang;
	logic                   flip;
	logic [Z_BITS-1:0]      z0;

	// stage 1: gain multiply
	logic                   v_s1;
	logic [PROD_BITS-1:0]   prod_s1;
	logic [Z_BITS-1:0]      z_s1;
	logic                   flip_s1;
	logic [GREEN_BITS-1:0]  green_s1;

	// CORDIC stages
	logic                       cv_s     [CORDIC_STEPS];
	logic signed [XY_BITS-1:0]  cx_s     [CORDIC_STEPS];
	logic signed [XY_BITS-1:0]  cy_s     [CORDIC_STEPS];
	logic signed [Z_BITS-1:0]   cz_s     [CORDIC_STEPS];
	logic                       cflip_s  [CORDIC_STEPS];
	logic [GREEN_BITS-1:0]      cgreen_s [CORDIC_STEPS];

	// stage 26: centre offset plus rounding half
	logic signed [XY_BITS-1:0] rs;
	logic signed [XY_BITS-1:0] rc;
	logic [Z_BITS-1:0]         cxr;
	logic [Z_BITS-1:0]         cyr;
	logic                      v_s26;
	logic [Z_BITS-1:0]         xr_s26;
	logic [Z_BITS-1:0]         yr_s26;
	logic [GREEN_BITS-1:0]     green_s26;

	// output register
	logic                  out_valid_q;
	logic [COORD_BITS-1:0] pixel_x_q;
	logic [COORD_BITS-1:0] pixel_y_q;
	logic [GREEN_BITS-1:0] pixel_green_q;
	logic [LIM_BITS-1:0]   wlim;
	logic [LIM_BITS-1:0]   hlim;
	logic                  on_image;

	assign en        = !out_valid_q || pixel_out.ready;
	assign pop_ready = en;

	assign pop_sum   = pop_data[PAY_BITS-1 -: SUM_BITS];
	assign pop_r     = pop_data[GREEN_BITS +: RADIUS_BITS];
	assign pop_green = pop_data[GREEN_BITS-1:0];

	// fold angles in the back half-turn onto the front half, negate later
	always_comb begin
		ang  = {pop_sum, {(31 - ANGLE_BITS){1'b0}}};
		flip = ang[31] ^ ang[30];
		z0   = flip ? {~ang[31], ang[30:0]} : ang;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1  <= PROD_BITS'(pop_r) * PROD_BITS'(CORDIC_GAIN_Q30);
			z_s1     <= z0;
			flip_s1  <= flip;
			green_s1 <= pop_green;
		end
	end

	// rotation mode CORDIC, one micro-rotation a stage
	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
		logic                      pv;
		logic signed [XY_BITS-1:0] px;
		logic signed [XY_BITS-1:0] py;
		logic signed [Z_BITS-1:0]  pz;
		logic                      pflip;
		logic [GREEN_BITS-1:0]     pgreen;
		logic signed [XY_BITS-1:0] sx;
		logic signed [XY_BITS-1:0] sy;
		logic signed [XY_BITS-1:0] nx;
		logic signed [XY_BITS-1:0] ny;
		logic signed [Z_BITS-1:0]  nz;

		if (k == 0) begin : g_first
			assign pv     = v_s1;
			assign px     = signed'(XY_BITS'(prod_s1[PROD_BITS-1:GAIN_BITS]));
			assign py     = '0;
			assign pz     = signed'(z_s1);
			assign pflip  = flip_s1;
			assign pgreen = green_s1;
		end else begin : g_next
			assign pv     = cv_s[k-1];
			assign px     = cx_s[k-1];
			assign py     = cy_s[k-1];
			assign pz     = cz_s[k-1];
			assign pflip  = cflip_s[k-1];
			assign pgreen = cgreen_s[k-1];
		end

		always_comb begin
			sx = px >>> k;
			sy = py >>> k;
			if (!pz[Z_BITS-1]) begin
				nx = px - sy;
				ny = py + sx;
				nz = pz - signed'(ATAN_TURN32[k]);
			end else begin
				nx = px + sy;
				ny = py - sx;
				nz = pz + signed'(ATAN_TURN32[k]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[k] <= 1'b0;
			end else if (en) begin
				cv_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cx_s[k]     <= nx;
				cy_s[k]     <= ny;
				cz_s[k]     <= nz;
				cflip_s[k]  <= pflip;
				cgreen_s[k] <= pgreen;
			end
		end
	end

	// undo the fold and add the centre, half a pixel included
	always_comb begin
		rs  = cflip_s[CORDIC_STEPS-1] ? -cy_s[CORDIC_STEPS-1] : cy_s[CORDIC_STEPS-1];
		rc  = cflip_s[CORDIC_STEPS-1] ? -cx_s[CORDIC_STEPS-1] : cx_s[CORDIC_STEPS-1];
		cxr = {4'b0, cfg.image_width, 15'b0} + HALF;
		cyr = {4'b0, cfg.image_height, 15'b0} + HALF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s26 <= 1'b0;
		end else if (en) begin
			v_s26 <= cv_s[CORDIC_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xr_s26    <= cxr + {rs[XY_BITS-1], rs};
			yr_s26    <= cyr - {rc[XY_BITS-1], rc};
			green_s26 <= cgreen_s[CORDIC_STEPS-1];
		end
	end

	// image bounds, with oversized images clamped to the coordinate range
	always_comb begin
		wlim = ({2'b0, cfg.image_width} > CMAX) ? CMAX : {2'b0, cfg.image_width};
		hlim = ({2'b0, cfg.image_height} > CMAX) ? CMAX : {2'b0, cfg.image_height};
		on_image = !xr_s26[Z_BITS-1] && (xr_s26[30:16] < wlim) &&
		           !yr_s26[Z_BITS-1] && (yr_s26[30:16] < hlim);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_s26 && on_image;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pixel_x_q     <= xr_s26[16 +: COORD_BITS];
			pixel_y_q     <= yr_s26[16 +: COORD_BITS];
			pixel_green_q <= green_s26;
		end
	end

	assign pixel_out.valid       = out_valid_q;
	assign pixel_out.pixel_x     = pixel_x_q;
	assign pixel_out.pixel_y     = pixel_y_q;
	assign pixel_out.pixel_green = pixel_green_q;

endmodule

// ----- src/radar_radial_scan_converter_unit.sv -----
// radar_radial_scan_converter_unit: top level of the radial scan converter.
// Holds the APB register file and joins front, queue and back.
// Depends on rrsc_pkg, rrsc_ifs, rrsc_front, rrsc_fifo and rrsc_back.
//
// Usage:
//   cell_in   (valid/ready sink): one radar range cell per transfer.
//   pixel_out (valid/ready source): zero or one pixel write per cell, in input order.
//   APB port: image_width at 0x0, image_height at 0x4, radius_q4 at 0x8,
//   pixels_per_cell at 0xC; write only while no cells are in flight.
// Throughput: one cell per clock while cell_in.ready is high; every stage is
//   pipelined and no unit is shared. The front takes 21 stages (input, two-part
//   multiply, radius check, a one-stage reciprocal count divide, a 16-stage index
//   modulo), the back 27 (gain multiply, 24 CORDIC stages, centre add, output
//   register). Dropped cells leave no transfer.
// Reset: registers return to 1024 x 1024, radius 7537 (Q12.4), 1.0 pixel per cell;
//   all pipelines and the queue come up empty.
// Stall: a pixel stuck on low pixel_out.ready holds the back; the front takes cells
//   until the 4-entry queue is full and a kept cell waits, then cell_in.ready drops.
`timescale 1ns / 1ps

module radar_radial_scan_converter_unit
	import rrsc_pkg::*;
#(
	parameter int MAX_CELLS_PER_RADIAL = 512,
	parameter int ANGLE_BITS = 16,
	parameter int COORD_BITS = 12
)(
	input  logic                     clk,
	input  logic                     arst_n,
	rrsc_in_if.sink                  cell_in,
	rrsc_out_if.source               pixel_out,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready
);

	localparam int PAY_BITS    = ANGLE_BITS + 1 + RADIUS_BITS + GREEN_BITS;
	localparam int QUEUE_DEPTH = 4;

	cfg_t                cfg_q;
	reg_idx_t            reg_idx;
	logic                cfg_wr;
	logic                push_valid;
	logic                push_ready;
	logic [PAY_BITS-1:0] push_data;
	logic                pop_valid;
	logic                pop_ready;
	logic [PAY_BITS-1:0] pop_data;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	// register writes, each keeps only its own width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width     <= RST_IMAGE_WIDTH;
			cfg_q.image_height    <= RST_IMAGE_HEIGHT;
			cfg_q.radius_q4       <= RST_RADIUS_Q4;
			cfg_q.pixels_per_cell <= RST_PIXELS_PER_CELL;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_IMAGE_WIDTH:     cfg_q.image_width     <= pwdata[12:0];
				REG_IMAGE_HEIGHT:    cfg_q.image_height    <= pwdata[12:0];
				REG_RADIUS_Q4:       cfg_q.radius_q4       <= pwdata[15:0];
				REG_PIXELS_PER_CELL: cfg_q.pixels_per_cell <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (reg_idx)
			REG_IMAGE_WIDTH:     prdata = {19'b0, cfg_q.image_width};
			REG_IMAGE_HEIGHT:    prdata = {19'b0, cfg_q.image_height};
			REG_RADIUS_Q4:       prdata = {16'b0, cfg_q.radius_q4};
			REG_PIXELS_PER_CELL: prdata = {8'b0, cfg_q.pixels_per_cell};
			default:             prdata = '0;
		endcase
	end

	rrsc_front #(
		.MAX_CELLS_PER_RADIAL (MAX_CELLS_PER_RADIAL),
		.ANGLE_BITS           (ANGLE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cell_in    (cell_in),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	rrsc_fifo #(
		.WIDTH (PAY_BITS),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push_valid),
		.in_ready  (push_ready),
		.in_data   (push_data),
		.out_valid (pop_valid),
		.out_ready (pop_ready),
		.out_data  (pop_data)
	);

	rrsc_back #(
		.ANGLE_BITS (ANGLE_BITS),
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.pixel_out (pixel_out)
	);

endmodule
